>>> rtl/ssvm_pkg.sv
`timescale 1ns / 1ps

package ssvm_pkg;

    // Default sizes, handed to the top level parameters
    localparam int DEF_SAMPLE_DEPTH = 16384;
    localparam int DEF_STEPS        = 16;
    localparam int DEF_VOICES       = 4;

    // Fixed field widths
    localparam int WORD_W      = 16;
    localparam int POS_W       = 14;
    localparam int COUNT_W     = 20;
    localparam int MIX_W       = 22;
    localparam int STEP_OUT_W  = 4;
    localparam int VOICE_IN_W  = 2;
    localparam int SMP_VOICE_W = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // Pattern registers cover this many voices and steps
    localparam int PATTERN_VOICES = 4;
    localparam int PATTERN_STEPS  = 16;

    localparam int MIX_MAX = 2097151;
    localparam int MIX_MIN = -2097152;

    localparam logic [WORD_W-1:0] RST_STEP_SAMPLES = 16'd6000;
    localparam logic [POS_W-1:0]  RST_PLAY_LENGTH  = 14'd9999;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DRUMS_ENABLE = 3'd0,
        REG_STEP_SAMPLES = 3'd1,
        REG_PLAY_LENGTH  = 3'd2,
        REG_PATTERN_V0   = 3'd3,
        REG_PATTERN_V1   = 3'd4,
        REG_PATTERN_V2   = 3'd5,
        REG_PATTERN_V3   = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic                         command;
        logic [VOICE_IN_W-1:0]        voice;
        logic [POS_W-1:0]             address;
        logic signed [WORD_W-1:0]     sample_value;
    } in_item_t;

    typedef struct packed {
        logic signed [MIX_W-1:0]      mix;
        logic [STEP_OUT_W-1:0]        current_step;
    } out_item_t;

    typedef struct packed {
        logic                         en;
        logic [SMP_VOICE_W-1:0]       voice;
        logic [POS_W-1:0]             address;
        logic [WORD_W-1:0]            value;
    } smp_wr_t;

    typedef struct packed {
        logic                         en;
        logic [SMP_VOICE_W-1:0]       voice;
        logic [POS_W-1:0]             pos;
    } smp_rd_t;

endpackage

>>> rtl/ssvm_stream_if.sv
`timescale 1ns / 1ps

interface ssvm_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/ssvm_sample_store.sv
`timescale 1ns / 1ps

module ssvm_sample_store #(
    parameter int SAMPLE_DEPTH = ssvm_pkg::DEF_SAMPLE_DEPTH,
    parameter int VOICES       = ssvm_pkg::DEF_VOICES
) (
    input  logic                        clk,
    input  ssvm_pkg::smp_wr_t           wr,
    input  ssvm_pkg::smp_rd_t           rd,
    output logic [ssvm_pkg::WORD_W-1:0] rdata
);
    import ssvm_pkg::*;

    localparam int WORDS = VOICES * SAMPLE_DEPTH;
    localparam int MAW   = $clog2(WORDS);

    logic [WORD_W-1:0] mem [WORDS];
    logic [WORD_W-1:0] rdata_reg;
    logic [31:0]       wa32;
    logic [31:0]       ra32;
    logic              wr_ok;

    // Drop loads aimed past the voice count or the memory depth
    assign wr_ok = wr.en && (32'(wr.voice) < 32'(VOICES))
                         && (32'(wr.address) < 32'(SAMPLE_DEPTH));
    assign wa32  = 32'(wr.voice) * 32'(SAMPLE_DEPTH) + 32'(wr.address);
    assign ra32  = 32'(rd.voice) * 32'(SAMPLE_DEPTH) + 32'(rd.pos);

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            mem[wa32[MAW-1:0]] <= wr.value;
        end
        if (rd.en)
        begin
            rdata_reg <= mem[ra32[MAW-1:0]];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/step_sequenced_sample_voice_mixer.sv
`timescale 1ns / 1ps

// Drum pattern player with sample voices.
// items (sink): command 0 is an audio tick, command 1 loads one sample word
// into a voice's sample memory. A load gives no result.
// A tick walks the playback instance memory (one entry per step and voice),
// one entry per cycle, arming, advancing and mixing as it goes; when the
// walk and the sample reads in flight have drained, its result (mix,
// current_step) is registered onto results, and the next item can be
// accepted from the cycle in which that result is presented.
// A tick holds the block until its result is registered; no item is
// accepted meanwhile.
// A new item is accepted while a result still waits in the output register;
// a tick only stalls at its end if the receiver still holds the earlier one.
// cfg_we/cfg_index/cfg_data write the configuration registers at any time
// the block is idle; unknown indexes are ignored.
// After reset a clearing pass zeroes the instance memory; no item is
// accepted during it. Sample memory is undefined until loaded.
module step_sequenced_sample_voice_mixer #(
    parameter int SAMPLE_DEPTH = ssvm_pkg::DEF_SAMPLE_DEPTH,
    parameter int STEPS        = ssvm_pkg::DEF_STEPS,
    parameter int VOICES       = ssvm_pkg::DEF_VOICES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ssvm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ssvm_pkg::CFG_DATA_W-1:0] cfg_data,
    ssvm_stream_if.sink                     items,
    ssvm_stream_if.source                   results
);
    import ssvm_pkg::*;

    localparam int INSTANCES = STEPS * VOICES;
    localparam int IW        = $clog2(INSTANCES);
    localparam int SIW       = $clog2(STEPS);
    localparam int VW        = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int ACC_W     = WORD_W + IW + 1;
    localparam int INST_W    = POS_W + 1;

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_WALK   = 5'b00100,
        ST_DRAIN  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Configuration
    logic              drums_enable_reg;
    logic [WORD_W-1:0] step_samples_reg;
    logic [POS_W-1:0]  play_length_reg;
    logic [WORD_W-1:0] pattern_reg [PATTERN_VOICES];

    // Sequencer
    logic [SIW-1:0]     step_reg, step_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;

    // Walk and pipeline
    logic [IW-1:0]      clr_reg;
    logic [VW-1:0]      wv_reg;
    logic [SIW-1:0]     ws_reg;
    logic               rd_vld_reg;
    logic [VW-1:0]      rd_voice_reg;
    logic [SIW-1:0]     rd_step_reg;
    logic [IW-1:0]      rd_idx_reg;
    logic               smp_vld_reg;
    logic signed [ACC_W-1:0] acc_reg;

    // Instance memory: {active, position}
    logic [INST_W-1:0]  inst_mem [INSTANCES];
    logic [INST_W-1:0]  inst_q_reg;
    logic               inst_we;
    logic [IW-1:0]      inst_waddr;
    logic [INST_W-1:0]  inst_wdata;
    logic [INST_W-1:0]  wb_data;

    // Output register
    logic               out_vld_reg;
    out_item_t          out_data_reg;
    out_item_t          out_data_next;

    logic               in_acc;
    logic               is_tick;
    logic               walk_last;
    logic [31:0]        walk_idx32;
    logic               out_free;

    logic               cur_active;
    logic [POS_W-1:0]   cur_pos;
    logic [POS_W-1:0]   pos_inc;
    logic [31:0]        pv32;
    logic [31:0]        ps32;
    logic               arm;
    logic               act_eff;
    logic               in_range;

    logic [SIW:0]       step_plus;
    logic [31:0]        prod32;
    logic [COUNT_W-1:0] cnt_inc;
    logic [31:0]        step32;
    logic signed [31:0] acc32;
    logic signed [31:0] sat32;

    smp_wr_t            smp_wr;
    smp_rd_t            smp_rd;
    logic [WORD_W-1:0]  smp_rdata;

    assign items.ready = (state_reg == ST_IDLE);
    assign in_acc      = items.valid && items.ready;
    assign is_tick     = (items.data.command == CMD_TICK);
    assign out_free    = !out_vld_reg || results.ready;

    assign walk_last  = (32'(wv_reg) == 32'(VOICES - 1)) && (32'(ws_reg) == 32'(STEPS - 1));
    assign walk_idx32 = 32'(wv_reg) * 32'(STEPS) + 32'(ws_reg);

    // Control FSM
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (32'(clr_reg) == 32'(INSTANCES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_acc && is_tick)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (walk_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_vld_reg && !smp_vld_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Arm, advance and write back the entry read last cycle
    always_comb
    begin
        cur_active = inst_q_reg[POS_W];
        cur_pos    = inst_q_reg[POS_W-1:0];
        pos_inc    = cur_pos + 1'b1;
        pv32       = 32'(rd_voice_reg);
        ps32       = 32'(step_reg);
        arm        = (ps32 < 32'(PATTERN_STEPS)) && (pv32 < 32'(PATTERN_VOICES))
                     && (rd_step_reg == step_reg)
                     && pattern_reg[pv32[1:0]][ps32[3:0]];
        act_eff    = cur_active || arm;
        in_range   = 32'(cur_pos) < 32'(SAMPLE_DEPTH);
        if (drums_enable_reg && act_eff)
        begin
            if (pos_inc == play_length_reg)
            begin
                wb_data = '0;
            end
            else
            begin
                wb_data = {1'b1, pos_inc};
            end
        end
        else
        begin
            wb_data = {act_eff, cur_pos};
        end
    end

    always_comb
    begin
        inst_we    = (state_reg == ST_CLEAR) || rd_vld_reg;
        inst_waddr = (state_reg == ST_CLEAR) ? clr_reg : rd_idx_reg;
        inst_wdata = (state_reg == ST_CLEAR) ? '0 : wb_data;
    end

    always_ff @(posedge clk)
    begin
        if (inst_we)
        begin
            inst_mem[inst_waddr] <= inst_wdata;
        end
        if (state_reg == ST_WALK)
        begin
            inst_q_reg <= inst_mem[walk_idx32[IW-1:0]];
        end
    end

    // Sample memory access
    always_comb
    begin
        smp_wr.en      = in_acc && (items.data.command == CMD_LOAD);
        smp_wr.voice   = SMP_VOICE_W'(items.data.voice);
        smp_wr.address = items.data.address;
        smp_wr.value   = items.data.sample_value;
        smp_rd.en      = rd_vld_reg && drums_enable_reg && act_eff && in_range;
        smp_rd.voice   = SMP_VOICE_W'(rd_voice_reg);
        smp_rd.pos     = cur_pos;
    end

    ssvm_sample_store #(
        .SAMPLE_DEPTH (SAMPLE_DEPTH),
        .VOICES       (VOICES)
    ) u_sample_store (
        .clk   (clk),
        .wr    (smp_wr),
        .rd    (smp_rd),
        .rdata (smp_rdata)
    );

    // Step counter update and output formatting
    always_comb
    begin
        step_plus = {1'b0, step_reg} + 1'b1;
        prod32    = 32'(step_plus) * 32'(step_samples_reg);
        cnt_inc   = cnt_reg + 1'b1;
        step_next = step_reg;
        cnt_next  = cnt_inc;
        if (cnt_inc == prod32[COUNT_W-1:0])
        begin
            if (32'(step_plus) >= 32'(STEPS))
            begin
                step_next = '0;
                cnt_next  = '0;
            end
            else
            begin
                step_next = step_plus[SIW-1:0];
            end
        end
        step32 = 32'(step_next);

        acc32 = {{(32 - ACC_W){acc_reg[ACC_W-1]}}, acc_reg};
        if (acc32 > MIX_MAX)
        begin
            sat32 = MIX_MAX;
        end
        else if (acc32 < MIX_MIN)
        begin
            sat32 = MIX_MIN;
        end
        else
        begin
            sat32 = acc32;
        end
        out_data_next.mix          = sat32[MIX_W-1:0];
        out_data_next.current_step = step32[STEP_OUT_W-1:0];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_reg          <= '0;
            rd_vld_reg       <= 1'b0;
            smp_vld_reg      <= 1'b0;
            out_vld_reg      <= 1'b0;
            step_reg         <= '0;
            cnt_reg          <= '0;
            drums_enable_reg <= 1'b0;
            step_samples_reg <= RST_STEP_SAMPLES;
            play_length_reg  <= RST_PLAY_LENGTH;
            for (int i = 0; i < PATTERN_VOICES; i++)
            begin
                pattern_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            rd_vld_reg  <= (state_reg == ST_WALK);
            smp_vld_reg <= smp_rd.en;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if ((state_reg == ST_FINISH) && out_free)
            begin
                out_vld_reg <= 1'b1;
                step_reg    <= step_next;
                cnt_reg     <= cnt_next;
            end
            else if (results.ready)
            begin
                out_vld_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_DRUMS_ENABLE: drums_enable_reg <= cfg_data[0];
                    REG_STEP_SAMPLES: step_samples_reg <= cfg_data;
                    REG_PLAY_LENGTH:  play_length_reg  <= cfg_data[POS_W-1:0];
                    REG_PATTERN_V0:   pattern_reg[0]   <= cfg_data;
                    REG_PATTERN_V1:   pattern_reg[1]   <= cfg_data;
                    REG_PATTERN_V2:   pattern_reg[2]   <= cfg_data;
                    REG_PATTERN_V3:   pattern_reg[3]   <= cfg_data;
                    default:          ;
                endcase
            end
        end
    end

    // Walk counters, pipeline payload and accumulator
    always_ff @(posedge clk)
    begin
        if (in_acc && is_tick)
        begin
            wv_reg  <= '0;
            ws_reg  <= '0;
            acc_reg <= '0;
        end
        else
        begin
            if (state_reg == ST_WALK)
            begin
                if (32'(ws_reg) == 32'(STEPS - 1))
                begin
                    ws_reg <= '0;
                    wv_reg <= wv_reg + 1'b1;
                end
                else
                begin
                    ws_reg <= ws_reg + 1'b1;
                end
            end
            if (smp_vld_reg)
            begin
                acc_reg <= acc_reg
                           + {{(ACC_W - WORD_W){smp_rdata[WORD_W-1]}}, smp_rdata};
            end
        end
        rd_voice_reg <= wv_reg;
        rd_step_reg  <= ws_reg;
        rd_idx_reg   <= walk_idx32[IW-1:0];
        if ((state_reg == ST_FINISH) && out_free)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign results.valid = out_vld_reg;
    assign results.data  = out_data_reg;

    // The mix is taken only once every read and sample in flight has landed
    a_finish_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |-> (!rd_vld_reg && !smp_vld_reg))
        else $error("finish reached with walk pipeline busy");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(results.valid) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside finish");

    a_read_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> $past(state_reg == ST_WALK))
        else $error("instance write-back without a walk read");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import ssvm_pkg::*;

    localparam int STEPS     = DEF_STEPS;
    localparam int VOICES    = DEF_VOICES;
    localparam int DEPTH     = DEF_SAMPLE_DEPTH;
    localparam int SLOTS     = STEPS * VOICES;
    localparam int SETTLE    = SLOTS + 12;
    localparam int RUN_LIMIT = 600000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic      item_valid = 1'b0;
    in_item_t  item_data = '0;
    logic      result_ready = 1'b0;

    ssvm_stream_if #(.payload_t(in_item_t))  item_ch ();
    ssvm_stream_if #(.payload_t(out_item_t)) result_ch ();

    assign item_ch.valid   = item_valid;
    assign item_ch.data    = item_data;
    assign result_ch.ready = result_ready;

    step_sequenced_sample_voice_mixer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .items     (item_ch),
        .results   (result_ch)
    );

    always #5 clk = ~clk;

    // Player state as the block should hold it
    logic signed [WORD_W-1:0] voice_mem [VOICES][DEPTH];
    bit                       armed [SLOTS];
    logic [POS_W-1:0]         play_pos [SLOTS];
    int unsigned              step_idx;
    logic [COUNT_W-1:0]       tick_count;

    bit                       drums_on;
    int unsigned              ticks_per_step;
    logic [POS_W-1:0]         hit_length;
    logic [15:0]              voice_pattern [PATTERN_VOICES];

    in_item_t   pending_items [$];
    out_item_t  expected_mixes [$];
    out_item_t  predicted;

    int  mismatches = 0;
    int  items_queued = 0;
    int  loaded_len = 0;
    bit  idle_on = 1'b1;
    bit  pressure_phase = 1'b0;
    int  send_gap;
    int  hold_left;
    bit  pressure_used;
    int unsigned cycle_count = 0;

    function automatic bit play_item(input in_item_t it, output out_item_t res);
        int               acc;
        int               k;
        logic [POS_W-1:0] pos;
        logic [COUNT_W-1:0] target;
        res = '0;
        if (it.command == CMD_LOAD)
        begin
            voice_mem[it.voice][it.address] = it.sample_value;
            return 1'b0;
        end
        acc = 0;
        for (int v = 0; v < VOICES; v++)
            if (voice_pattern[v][step_idx])
                armed[v * STEPS + step_idx] = 1'b1;
        if (drums_on)
        begin
            for (int v = 0; v < VOICES; v++)
            begin
                for (int s = 0; s < STEPS; s++)
                begin
                    k = v * STEPS + s;
                    if (armed[k])
                    begin
                        pos = play_pos[k];
                        acc += voice_mem[v][pos];
                        pos = pos + 1'b1;
                        if (pos == hit_length)
                        begin
                            pos = '0;
                            armed[k] = 1'b0;
                        end
                        play_pos[k] = pos;
                    end
                end
            end
        end
        if (acc > MIX_MAX)
            acc = MIX_MAX;
        else if (acc < MIX_MIN)
            acc = MIX_MIN;
        tick_count = tick_count + 1'b1;
        target = COUNT_W'((step_idx + 1) * ticks_per_step);
        if (tick_count == target)
        begin
            if (step_idx == STEPS - 1)
            begin
                step_idx = 0;
                tick_count = '0;
            end
            else
                step_idx++;
        end
        res.mix = MIX_W'(acc);
        res.current_step = STEP_OUT_W'(step_idx);
        return 1'b1;
    endfunction

    function automatic int deepest_position();
        int deepest = 0;
        for (int k = 0; k < SLOTS; k++)
            if (armed[k] && play_pos[k] > deepest)
                deepest = play_pos[k];
        return deepest;
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return WORD_W'($urandom);
        endcase
    endfunction

    task automatic check_mix(input out_item_t got);
        out_item_t want;
        if (expected_mixes.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: mix %0d step %0d", got.mix, got.current_step);
        end
        else
        begin
            want = expected_mixes.pop_front();
            if (got.mix !== want.mix || got.current_step !== want.current_step)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: mix exp %0d got %0d, step exp %0d got %0d",
                             want.mix, got.mix, want.current_step, got.current_step);
            end
        end
    endtask

    // Item driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (item_valid && item_ch.ready)
            begin
                if (play_item(item_data, predicted))
                    expected_mixes.push_back(predicted);
            end
            if (!item_valid || item_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    item_valid <= 1'b0;
                end
                else if (pending_items.size() != 0 && idle_on && $urandom_range(0, 5) == 0)
                begin
                    send_gap <= $urandom_range(0, 6);
                    item_valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    item_data <= pending_items.pop_front();
                    item_valid <= 1'b1;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // Result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            hold_left <= 0;
            pressure_used <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ready)
                check_mix(result_ch.data);
            // hold off long enough for the block to back up into its input
            if (pressure_phase && !pressure_used)
            begin
                pressure_used <= 1'b1;
                hold_left <= 1500;
                result_ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                result_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                hold_left <= $urandom_range(0, 6);
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input int unsigned val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(val);
        case (idx)
            REG_DRUMS_ENABLE: drums_on = val[0];
            REG_STEP_SAMPLES: ticks_per_step = val & 32'hFFFF;
            REG_PLAY_LENGTH:  hit_length = POS_W'(val);
            default:          voice_pattern[idx - REG_PATTERN_V0] = 16'(val);
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_load(input int v, input int addr, input logic [WORD_W-1:0] word);
        in_item_t it;
        it.command = CMD_LOAD;
        it.voice = VOICE_IN_W'(v);
        it.address = POS_W'(addr);
        it.sample_value = word;
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic push_tick();
        in_item_t it;
        it = in_item_t'($urandom);
        it.command = CMD_TICK;
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || item_valid || expected_mixes.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Load every address the coming ticks can reach, then tick with loads mixed in
    task automatic queue_phase(input int n_ticks, input int n_loads);
        int need;
        need = deepest_position() + n_ticks;
        if (need > DEPTH)
            need = DEPTH;
        while (loaded_len < need)
        begin
            for (int v = 0; v < VOICES; v++)
                push_load(v, loaded_len, pick_word());
            loaded_len++;
        end
        for (int i = 0; i < n_ticks; i++)
        begin
            if ($urandom_range(0, n_ticks - 1) < n_loads)
                push_load($urandom_range(0, VOICES - 1), $urandom_range(0, DEPTH - 1),
                          WORD_W'($urandom));
            push_tick();
        end
        wait_drained();
    endtask

    task automatic random_phase(input int n_ticks);
        int unsigned ss;
        int unsigned pl;
        int          deepest;
        deepest = deepest_position();
        write_reg(REG_DRUMS_ENABLE, $urandom_range(0, 7) != 0);
        case ($urandom_range(0, 9))
            0: ss = 65535;
            1: ss = $urandom_range(5, 300);
            default: ss = $urandom_range(1, 4);
        endcase
        // keep the step moving: if the counter is already past the new boundary, raise the step length
        if (COUNT_W'((step_idx + 1) * ss) <= tick_count)
            ss = tick_count / (step_idx + 1) + 1 + $urandom_range(0, 3);
        if (ss > 65535)
            ss = 65535;
        write_reg(REG_STEP_SAMPLES, ss);
        case ($urandom_range(0, 9))
            0: pl = 0;
            1: pl = 16383;
            2: pl = $urandom_range(21, 16382);
            default: pl = $urandom_range(1, 20);
        endcase
        // cut long hits short so the loaded range stays small
        if (deepest > 16)
            pl = deepest + 1 + $urandom_range(0, 4);
        write_reg(REG_PLAY_LENGTH, pl);
        for (int v = 0; v < PATTERN_VOICES; v++)
        begin
            case ($urandom_range(0, 7))
                0: write_reg(cfg_reg_t'(REG_PATTERN_V0 + v), 16'h0000);
                1: write_reg(cfg_reg_t'(REG_PATTERN_V0 + v), 16'hFFFF);
                2: write_reg(cfg_reg_t'(REG_PATTERN_V0 + v), $urandom & $urandom & 16'hFFFF);
                default: write_reg(cfg_reg_t'(REG_PATTERN_V0 + v), $urandom & 16'hFFFF);
            endcase
        end
        queue_phase(n_ticks, $urandom_range(0, 4));
    endtask

    initial
    begin
        int random_start;
        int phase_no;
        for (int k = 0; k < SLOTS; k++)
        begin
            armed[k] = 1'b0;
            play_pos[k] = '0;
        end
        for (int v = 0; v < PATTERN_VOICES; v++)
            voice_pattern[v] = '0;
        step_idx = 0;
        tick_count = '0;
        drums_on = 1'b0;
        ticks_per_step = RST_STEP_SAMPLES;
        hit_length = RST_PLAY_LENGTH;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        wait_drained();

        // reset values: silent, step held at zero
        queue_phase(2, 0);

        // short hits re-armed within their step
        write_reg(REG_DRUMS_ENABLE, 1);
        write_reg(REG_STEP_SAMPLES, 4);
        write_reg(REG_PLAY_LENGTH, 2);
        write_reg(REG_PATTERN_V0, 16'h0001);
        write_reg(REG_PATTERN_V1, 16'h8003);
        write_reg(REG_PATTERN_V2, 16'hFFFF);
        write_reg(REG_PATTERN_V3, 16'h0000);
        push_load(3, DEPTH - 1, 16'h8000);
        queue_phase(6, 1);

        // muted: still armed, nothing advances
        write_reg(REG_DRUMS_ENABLE, 0);
        queue_phase(3, 0);

        write_reg(REG_DRUMS_ENABLE, 1);
        write_reg(REG_PLAY_LENGTH, 16383);
        write_reg(REG_STEP_SAMPLES, 2);
        queue_phase(4, 0);
        // hits already past the new length run on
        write_reg(REG_PLAY_LENGTH, 1);
        queue_phase(3, 0);
        write_reg(REG_PLAY_LENGTH, 0);
        queue_phase(2, 0);
        // counter may now be past the step boundary
        write_reg(REG_STEP_SAMPLES, 1);
        queue_phase(2, 0);

        random_start = items_queued;
        phase_no = 0;
        while (items_queued - random_start < 650)
        begin
            idle_on = (items_queued - random_start) < 540;
            pressure_phase = (phase_no == 2);
            random_phase(pressure_phase ? 24 : $urandom_range(8, 20));
            pressure_phase = 1'b0;
            phase_no++;
        end

        wait_drained();
        if (mismatches == 0 && expected_mixes.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> sim.f
rtl/ssvm_pkg.sv
rtl/ssvm_stream_if.sv
rtl/ssvm_sample_store.sv
rtl/step_sequenced_sample_voice_mixer.sv
tb/tb_top.sv
